>>> rtl/fgbc_pkg.sv
// Shared types and constants for the FIFO ghost block cache.
package fgbc_pkg;

  localparam int BLK_W  = 32;
  localparam int CFG_W  = 10;
  localparam int HELD_W = 10;
  localparam int CNT_W  = 32;
  localparam int GRP_W  = 32;
  localparam logic [CFG_W-1:0] CAP_RESET = 10'd512;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_UPD
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic cmp;
    logic red;
    logic upd;
  } step_t;

  typedef struct packed {
    logic cmp;
    logic wr;
    logic shift;
  } cell_ctl_t;

endpackage

>>> rtl/fgbc_cell.sv
// One storage cell of the entry chain: block number, valid bit and match flag.
module fgbc_cell #(
  parameter int IDX  = 0,
  parameter int PW   = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fgbc_pkg::cell_ctl_t       ctl,
  input  logic [PW-1:0]             wp,
  input  logic [fgbc_pkg::BLK_W-1:0] key,
  input  logic [fgbc_pkg::BLK_W-1:0] nb_blk,
  input  logic                      nb_vld,
  output logic [fgbc_pkg::BLK_W-1:0] blk,
  output logic                      vld,
  output logic                      match
);
  import fgbc_pkg::*;

  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic             vld_r, vld_nxt;
  logic             match_r;
  logic             at_wp;

  assign at_wp = (wp == PW'(IDX));

  // The new entry lands at the write position; on an eviction everything
  // else moves one cell toward the oldest end.
  always_comb begin
    if (at_wp) begin
      blk_nxt = key;
      vld_nxt = 1'b1;
    end else if (ctl.shift) begin
      blk_nxt = nb_blk;
      vld_nxt = nb_vld;
    end else begin
      blk_nxt = blk_r;
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.wr) begin
        vld_r <= vld_nxt;
      end
      if (ctl.cmp) begin
        match_r <= vld_r && (blk_r == key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      blk_r <= blk_nxt;
    end
  end

  assign blk   = blk_r;
  assign vld   = vld_r;
  assign match = match_r;

endmodule

>>> rtl/fgbc_ctrl.sv
// Sequencer stepping one request through compare, reduce and update.
module fgbc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_free,
  output logic            in_stall,
  output fgbc_pkg::step_t step
);
  import fgbc_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_RED;
      end
      ST_RED: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    step        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        step.accept = in_valid;
      end
      ST_CMP: begin
        step.cmp = 1'b1;
      end
      ST_RED: begin
        step.red = 1'b1;
      end
      ST_UPD: begin
        step.upd = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/fifo_ghost_block_cache.sv
// Steps from the edge that accepts an input beat to the edge that loads its result beat: per-cell
// compare, grouped OR of match flags, final OR with chain update and output load.
// Requests are taken one at a time: in_stall stays high through compare, reduce and update, and
// a new request is taken while the previous result still waits on out_stall.
// Reset (synchronous, rst_n low): clears all valid bits, occupancy and both counters, and
// sets capacity to 512; stored block numbers are not cleared.
module fifo_ghost_block_cache #(
  parameter int MAX_ENTRIES = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [fgbc_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fgbc_pkg::BLK_W-1:0]  in_block_number,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic                        out_evicted_valid,
  output logic [fgbc_pkg::BLK_W-1:0]  out_evicted_block,
  output logic [fgbc_pkg::HELD_W-1:0] out_entries_held,
  output logic [fgbc_pkg::CNT_W-1:0]  out_lookup_total,
  output logic [fgbc_pkg::CNT_W-1:0]  out_hit_total
);
  import fgbc_pkg::*;

  localparam int OW    = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW  = (OW > CFG_W) ? OW : CFG_W;
  localparam int NGRP  = (MAX_ENTRIES + GRP_W - 1) / GRP_W;
  localparam int PADW  = NGRP * GRP_W;

  step_t     step;
  cell_ctl_t cell_ctl;
  logic      out_free;

  logic [CFG_W-1:0] cap_r;
  logic [BLK_W-1:0] key_r;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [CNT_W-1:0] lookup_r, hit_cnt_r;
  logic [NGRP-1:0]  grp_r;

  logic [BLK_W-1:0] blk_v [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] vld_v;
  logic [MAX_ENTRIES-1:0] match_v;
  logic [PADW-1:0]  match_pad;

  logic [CMPW-1:0]  cap_ext, max_ext, eff_cap, occ_ext;
  logic             hit, evict;
  logic [OW-1:0]    wp;

  logic                out_valid_r;
  logic                out_hit_r, out_ev_vld_r;
  logic [BLK_W-1:0]    out_ev_blk_r;
  logic [HELD_W-1:0]   out_held_r;
  logic [CNT_W-1:0]    out_lookup_r, out_hit_tot_r;

  assign out_free = !out_valid_r || !out_stall;

  fgbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_stall (in_stall),
    .step     (step)
  );

  // Capacity of zero behaves as one; anything beyond the chain length is clipped.
  assign cap_ext = CMPW'(cap_r);
  assign max_ext = CMPW'(MAX_ENTRIES);
  assign occ_ext = CMPW'(occ_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > max_ext) begin
      eff_cap = max_ext;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign hit   = |grp_r;
  assign evict = !hit && (occ_ext >= eff_cap);
  assign wp    = evict ? (occ_r - OW'(1)) : occ_r;

  always_comb begin
    if (hit) begin
      occ_nxt = occ_r;
    end else if (evict) begin
      occ_nxt = occ_r;
    end else begin
      occ_nxt = occ_r + OW'(1);
    end
  end

  assign cell_ctl.cmp   = step.cmp;
  assign cell_ctl.wr    = step.upd && !hit;
  assign cell_ctl.shift = evict;

  // Cell 0 always holds the oldest entry; new entries fill from the low end.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [BLK_W-1:0] nb_blk;
    logic             nb_vld;
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nb_blk = '0;
      assign nb_vld = 1'b0;
    end else begin : g_mid
      assign nb_blk = blk_v[i+1];
      assign nb_vld = vld_v[i+1];
    end
    fgbc_cell #(
      .IDX (i),
      .PW  (OW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (cell_ctl),
      .wp     (wp),
      .key    (key_r),
      .nb_blk (nb_blk),
      .nb_vld (nb_vld),
      .blk    (blk_v[i]),
      .vld    (vld_v[i]),
      .match  (match_v[i])
    );
  end

  assign match_pad = PADW'(match_v);

  always_ff @(posedge clk) begin
    if (step.accept) begin
      key_r <= in_block_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r <= '0;
    end else if (step.red) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= |match_pad[g*GRP_W +: GRP_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      occ_r     <= '0;
      lookup_r  <= '0;
      hit_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (step.upd) begin
        occ_r    <= occ_nxt;
        lookup_r <= lookup_r + CNT_W'(1);
        if (hit) begin
          hit_cnt_r <= hit_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.upd) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.upd) begin
      out_hit_r     <= hit;
      out_ev_vld_r  <= evict;
      out_ev_blk_r  <= evict ? blk_v[0] : '0;
      out_held_r    <= HELD_W'(occ_nxt);
      out_lookup_r  <= lookup_r + CNT_W'(1);
      out_hit_tot_r <= hit ? (hit_cnt_r + CNT_W'(1)) : hit_cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_block = out_ev_blk_r;
  assign out_entries_held  = out_held_r;
  assign out_lookup_total  = out_lookup_r;
  assign out_hit_total     = out_hit_tot_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_ext <= max_ext)
    else $error("occupancy exceeds the cell chain length");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_v) == int'(occ_r))
    else $error("cell valid bits disagree with occupancy");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    step.upd && evict |=> occ_r == $past(occ_r))
    else $error("eviction changed occupancy");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_valid |-> !out_hit)
    else $error("eviction reported on a hit");

  a_update_frees_output: assert property (@(posedge clk) disable iff (!rst_n)
    step.upd |=> out_valid)
    else $error("update did not load a result beat");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the FIFO ghost block cache.
`timescale 1ns / 100ps

module testbench;
  import fgbc_pkg::*;

  localparam int GHOST_DEPTH = 512;
  localparam int DRAIN_GAP   = 8;
  localparam int HOLD_CYCLES = 120;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic              hit;
    logic              ev_valid;
    logic [BLK_W-1:0]  ev_block;
    logic [HELD_W-1:0] held;
    logic [CNT_W-1:0]  lookups;
    logic [CNT_W-1:0]  hits;
  } lookup_result_t;

  typedef struct {
    bit                is_cfg;
    logic [CFG_W-1:0]  cap;
    logic [BLK_W-1:0]  blk;
    bit                typed;
    lookup_result_t    want;
  } plan_row_t;

  typedef struct {
    logic [CFG_W-1:0] cap;
    int               count;
  } phase_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [BLK_W-1:0]  in_block_number;
  logic              out_valid;
  logic              out_stall;
  logic              out_hit;
  logic              out_evicted_valid;
  logic [BLK_W-1:0]  out_evicted_block;
  logic [HELD_W-1:0] out_entries_held;
  logic [CNT_W-1:0]  out_lookup_total;
  logic [CNT_W-1:0]  out_hit_total;

  // Predictor state: the remembered block numbers kept as a ring.
  logic [BLK_W-1:0]  ghost_blocks [GHOST_DEPTH];
  bit                ghost_live [GHOST_DEPTH];
  int unsigned       ghost_count;
  int unsigned       ghost_head;
  logic [CNT_W-1:0]  lookups_seen;
  logic [CNT_W-1:0]  hits_seen;
  logic [CFG_W-1:0]  cap_reg;

  lookup_result_t    pending_q [$];
  logic [BLK_W-1:0]  recent_q [$];
  plan_row_t         plan [$];
  phase_t            phases [$];

  int  mismatch_count;
  int  beats_sent;
  int  beats_checked;
  int  hits_checked;
  int  evictions_checked;
  int  idle_pct;
  bit  hold_req;

  fifo_ghost_block_cache #(
    .MAX_ENTRIES(GHOST_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_block_number  (in_block_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_block(out_evicted_block),
    .out_entries_held (out_entries_held),
    .out_lookup_total (out_lookup_total),
    .out_hit_total    (out_hit_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_q.size());
    $display("fifo_ghost_block_cache regression: fail");
    $finish;
  end

  task automatic note_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Looks the block number up in the ghost ring and applies the FIFO update.
  function automatic lookup_result_t ghost_lookup(input logic [BLK_W-1:0] blk);
    lookup_result_t res;
    int unsigned    limit;
    int unsigned    slot;
    res = '0;
    lookups_seen = lookups_seen + 1'b1;
    for (int i = 0; i < GHOST_DEPTH; i++) begin
      if (ghost_live[i] && ghost_blocks[i] == blk) res.hit = 1'b1;
    end
    limit = (cap_reg == 0) ? 1 : ((cap_reg > GHOST_DEPTH) ? GHOST_DEPTH : cap_reg);
    if (res.hit) begin
      hits_seen = hits_seen + 1'b1;
    end else begin
      if (ghost_count >= limit && ghost_count > 0) begin
        res.ev_valid = 1'b1;
        res.ev_block = ghost_blocks[ghost_head];
        ghost_live[ghost_head] = 1'b0;
        ghost_head = (ghost_head + 1) % GHOST_DEPTH;
        ghost_count--;
      end
      slot = (ghost_head + ghost_count) % GHOST_DEPTH;
      ghost_blocks[slot] = blk;
      ghost_live[slot] = 1'b1;
      ghost_count++;
    end
    res.held = HELD_W'(ghost_count);
    res.lookups = lookups_seen;
    res.hits = hits_seen;
    return res;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_W-1:0] cap);
    plan_row_t row;
    row = '{is_cfg: 1'b1, cap: cap, blk: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t lookup_row(input logic [BLK_W-1:0] blk);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, blk: blk, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic [BLK_W-1:0] blk, input logic hit,
                                          input logic ev, input logic [BLK_W-1:0] ev_blk,
                                          input int held, input int looks, input int hits);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, blk: blk, typed: 1'b1, want: '0};
    row.want.hit = hit;
    row.want.ev_valid = ev;
    row.want.ev_block = ev_blk;
    row.want.held = HELD_W'(held);
    row.want.lookups = CNT_W'(looks);
    row.want.hits = CNT_W'(hits);
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_lookup(input logic [BLK_W-1:0] blk, input bit typed,
                             input lookup_result_t want);
    lookup_result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_block_number <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = ghost_lookup(blk);
    pending_q.push_back(typed ? want : predicted);
    recent_q.push_back(blk);
    if (recent_q.size() > 16) void'(recent_q.pop_front());
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = value;
  endtask

  // Receiver: random stalls, plus one long hold-off when the sender asks for it.
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        note_mismatch("result beat with no lookup outstanding");
      end else begin
        want = pending_q.pop_front();
        beats_checked++;
        if (out_hit) hits_checked++;
        if (out_evicted_valid) evictions_checked++;
        if (out_hit !== want.hit)
          note_mismatch($sformatf("lookup %0d hit: got %b want %b",
                                  want.lookups, out_hit, want.hit));
        if (out_evicted_valid !== want.ev_valid)
          note_mismatch($sformatf("lookup %0d evicted_valid: got %b want %b",
                                  want.lookups, out_evicted_valid, want.ev_valid));
        if (out_evicted_block !== want.ev_block)
          note_mismatch($sformatf("lookup %0d evicted_block: got %h want %h",
                                  want.lookups, out_evicted_block, want.ev_block));
        if (out_entries_held !== want.held)
          note_mismatch($sformatf("lookup %0d entries_held: got %0d want %0d",
                                  want.lookups, out_entries_held, want.held));
        if (out_lookup_total !== want.lookups)
          note_mismatch($sformatf("lookup %0d lookup_total: got %0d",
                                  want.lookups, out_lookup_total));
        if (out_hit_total !== want.hits)
          note_mismatch($sformatf("lookup %0d hit_total: got %0d want %0d",
                                  want.lookups, out_hit_total, want.hits));
      end
    end
  end

  initial begin
    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] phase_base;
    int unsigned      span;
    int unsigned      walk;
    int unsigned      limit;
    int               pick;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_block_number = '0;
    hold_req = 1'b0;
    idle_pct = 38;
    mismatch_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    hits_checked = 0;
    evictions_checked = 0;
    for (int i = 0; i < GHOST_DEPTH; i++) begin
      ghost_blocks[i] = '0;
      ghost_live[i] = 1'b0;
    end
    ghost_count = 0;
    ghost_head = 0;
    lookups_seen = '0;
    hits_seen = '0;
    cap_reg = CAP_RESET;

    // Directed part: capacity one and zero first, while the ring is nearly empty.
    plan.push_back(cfg_row(10'd1));
    plan.push_back(known_row(32'h0000_0000, 1'b0, 1'b0, 32'h0, 1, 1, 0));
    plan.push_back(known_row(32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, 1, 2, 0));
    plan.push_back(known_row(32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1, 3, 1));
    plan.push_back(known_row(32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1, 4, 1));
    plan.push_back(cfg_row(10'd0));
    plan.push_back(known_row(32'h0000_0000, 1'b1, 1'b0, 32'h0, 1, 5, 2));
    plan.push_back(known_row(32'h0000_0001, 1'b0, 1'b1, 32'h0, 1, 6, 2));
    plan.push_back(cfg_row(10'd1023));
    plan.push_back(known_row(32'h0000_0002, 1'b0, 1'b0, 32'h0, 2, 7, 2));
    plan.push_back(lookup_row(32'h8000_0000));
    plan.push_back(lookup_row(32'h7FFF_FFFF));
    plan.push_back(lookup_row(32'h0000_0001));
    // Capacity below occupancy: each miss swaps one entry, none are dropped.
    plan.push_back(cfg_row(10'd2));
    plan.push_back(lookup_row(32'hAAAA_AAAA));
    plan.push_back(lookup_row(32'h5555_5555));
    plan.push_back(lookup_row(32'h0000_0002));
    plan.push_back(cfg_row(10'd512));
    plan.push_back(lookup_row(32'hFFFF_FFFE));

    phases.push_back('{10'd3, 100});
    phases.push_back('{10'd40, 150});
    phases.push_back('{10'd200, 250});
    phases.push_back('{10'd512, 800});
    phases.push_back('{10'd2, 80});
    phases.push_back('{10'd1, 60});
    phases.push_back('{10'd0, 60});
    phases.push_back('{10'd1023, 100});
    phases.push_back('{10'd64, 100});

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        wait_drained();
        write_capacity(plan[r].cap);
      end else begin
        send_lookup(plan[r].blk, plan[r].typed, plan[r].want);
      end
    end

    foreach (phases[p]) begin
      wait_drained();
      write_capacity(phases[p].cap);
      limit = (cap_reg == 0) ? 1 : ((cap_reg > GHOST_DEPTH) ? GHOST_DEPTH : cap_reg);
      span = 2 * limit + 4;
      walk = 0;
      phase_base = $urandom();
      // The capacity-200 phase runs with neither side idling.
      idle_pct = (phases[p].cap == 10'd200) ? 0 : 38;
      for (int n = 0; n < phases[p].count; n++) begin
        if (phases[p].cap == 10'd512 && n == 300) hold_req = 1'b1;
        if (phases[p].cap == 10'd40 && n == 75) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          blk = $urandom();
        end else if (pick < 30) begin
          blk = recent_q[$urandom_range(0, recent_q.size() - 1)];
        end else if (pick < 60) begin
          // A sequential sweep fills the ring and then cycles it in FIFO order.
          blk = phase_base + BLK_W'(walk % span);
          walk++;
        end else begin
          blk = phase_base + BLK_W'($urandom_range(0, span - 1));
        end
        send_lookup(blk, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_GAP) @(posedge clk);
    $display("%0d lookups sent, %0d results checked: %0d hits, %0d evictions",
             beats_sent, beats_checked, hits_checked, evictions_checked);
    $display("capacities 0 to 1023 exercised, including shrinking below occupancy");
    if (mismatch_count == 0 && pending_q.size() == 0) begin
      $display("fifo_ghost_block_cache regression: pass");
    end else begin
      $display("fifo_ghost_block_cache regression: fail");
    end
    $finish;
  end

endmodule
